### design/websocket_text_frame_parser_macros.svh
// assertion macros for the websocket text frame parser
`ifndef WEBSOCKET_TEXT_FRAME_PARSER_MACROS_SVH
`define WEBSOCKET_TEXT_FRAME_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WTFP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WTFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/wtfp_pkg.sv
// types and constants for the websocket text frame parser
package wtfp_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXTH = 3'd2,
    PH_EXTL = 3'd3,
    PH_KEY  = 3'd4,
    PH_DATA = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_LEN64 = 2'd2,
    KIND_OPERR = 2'd3
  } kind_t;

  localparam logic [3:0] OPCODE_TEXT = 4'h1;
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

endpackage

### design/websocket_text_frame_parser.sv
// websocket text frame parser: header decode, unmasking and result register
//
//   channel | ports                                 | direction
//   --------+---------------------------------------+----------
//   in      | in_valid, in_ready, in_rx_byte        | input
//   out     | out_valid, out_ready, out_kind,       | output
//           | out_payload_byte, out_last            |
//
// one byte per cycle while the output is not stalled: each request is decoded in the cycle it is accepted
// and its result, if any, sits in the output register on the next cycle.
// in_ready is high whenever the output register is empty or being drained.
// a stalled output holds the parser state and blocks further requests.
// synchronous active-low reset returns the parser to the first header byte.
module websocket_text_frame_parser
  import wtfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_payload_byte,
  output logic       out_last
);

`include "websocket_text_frame_parser_macros.svh"

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] index_r, index_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  sub_r, sub_nxt;

  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic        accept;
  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [6:0]  len_code;
  logic [15:0] len_now;
  logic        hdr_done;
  logic        text_frame;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign len_code = in_rx_byte[6:0];
  assign text_frame = (opcode_r == OPCODE_TEXT);

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    length_nxt = length_r;
    index_nxt  = index_r;
    key_nxt    = key_r;
    sub_nxt    = sub_r;
    res_valid  = 1'b0;
    res_kind   = KIND_DATA;
    res_byte   = 8'h00;
    res_last   = 1'b0;
    len_now    = length_r;
    hdr_done   = 1'b0;

    unique case (phase_r)
      PH_HDR1: begin
        masked_nxt = in_rx_byte[7];
        key_nxt    = 32'h0;
        if (len_code == LEN_CODE_EXT64) begin
          phase_nxt = PH_HDR0;
          res_valid = 1'b1;
          res_kind  = KIND_LEN64;
          res_last  = 1'b1;
        end else if (len_code == LEN_CODE_EXT16) begin
          phase_nxt = PH_EXTH;
        end else begin
          len_now    = {9'd0, len_code};
          length_nxt = len_now;
          if (in_rx_byte[7]) begin
            sub_nxt   = 2'd0;
            phase_nxt = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXTH: begin
        length_nxt = {in_rx_byte, 8'h00};
        phase_nxt  = PH_EXTL;
      end
      PH_EXTL: begin
        len_now    = {length_r[15:8], in_rx_byte};
        length_nxt = len_now;
        if (masked_r) begin
          sub_nxt   = 2'd0;
          phase_nxt = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_nxt[sub_r*8 +: 8] = in_rx_byte;
        sub_nxt = sub_r + 2'd1;
        if (sub_r == 2'd3) begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        index_nxt = index_r + 16'd1;
        res_last  = (index_nxt == length_r);
        if (res_last) begin
          phase_nxt = PH_HDR0;
        end
        if (text_frame) begin
          res_valid = 1'b1;
          res_kind  = KIND_DATA;
          res_byte  = in_rx_byte ^ key_r[index_r[1:0]*8 +: 8];
        end else if (res_last) begin
          res_valid = 1'b1;
          res_kind  = KIND_OPERR;
        end
      end
      default: begin
        opcode_nxt = in_rx_byte[3:0];
        phase_nxt  = PH_HDR1;
      end
    endcase

    // header complete: empty frames report at once, others go to payload
    if (hdr_done) begin
      if (len_now == 16'd0) begin
        phase_nxt = PH_HDR0;
        res_valid = 1'b1;
        res_kind  = text_frame ? KIND_EMPTY : KIND_OPERR;
        res_last  = 1'b1;
      end else begin
        index_nxt = 16'd0;
        phase_nxt = PH_DATA;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (accept) begin
      out_valid_nxt = res_valid;
      out_kind_nxt  = res_kind;
      out_byte_nxt  = res_byte;
      out_last_nxt  = res_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      opcode_r    <= 4'h0;
      masked_r    <= 1'b0;
      length_r    <= 16'h0;
      index_r     <= 16'h0;
      key_r       <= 32'h0;
      sub_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        opcode_r <= opcode_nxt;
        masked_r <= masked_nxt;
        length_r <= length_nxt;
        index_r  <= index_nxt;
        key_r    <= key_nxt;
        sub_r    <= sub_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_payload_byte = out_byte_r;
  assign out_last         = out_last_r;

  // error, 64-bit-length and empty results always close the frame
  `WTFP_ASSERT_IMPLY(a_nondata_last, out_valid_r && out_kind_r != KIND_DATA, out_last_r, "non-data result without last")

  // a waiting frame-end result means the parser is back at the header
  `WTFP_ASSERT_IMPLY(a_last_hdr, out_valid_r && out_last_r, phase_r == PH_HDR0, "frame end not followed by header phase")

  // key bytes are only collected for masked frames
  `WTFP_ASSERT_IMPLY(a_key_masked, phase_r == PH_KEY, masked_r, "key phase on unmasked frame")

  // a request at the last key byte leaves the key phase
  `WTFP_ASSERT_NEXT(a_key_exit, accept && phase_r == PH_KEY && sub_r == 2'd3, phase_r != PH_KEY, "key phase overran four bytes")

endmodule
